### rtl/skl_pkg.sv
// skl_pkg: shared constants and types of the skyline sweep block
// used by skl_heap_eng, skyline_sweep_max_heap and the testbench
package skl_pkg;

  localparam int unsigned HEAP_DEPTH  = 32;
  localparam int unsigned COORD_BITS  = 32;
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned ENT_W       = 2 * COORD_BITS;
  localparam int unsigned HADDR_W     = $clog2(HEAP_DEPTH);
  localparam int unsigned CHILD_W     = HADDR_W + 1;
  localparam int unsigned CNT_W       = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned MAX_RESULTS = HEAP_DEPTH + 2;
  localparam int unsigned BUF_AW      = $clog2(MAX_RESULTS);
  localparam int unsigned BCNT_W      = $clog2(HEAP_DEPTH + 4);

  // heap entry: height in the upper half, right edge in the lower half
  typedef logic [ENT_W-1:0] ent_t;

  typedef struct packed {
    logic push;
    logic pop;
    ent_t ent;
  } heap_cmd_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
    ent_t             top;
  } heap_sts_t;

endpackage

### rtl/skl_ram.sv
// skl_ram: generic simple dual-port ram, one write and one registered read
// no package dependency
module skl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [2**AW];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/skl_heap_eng.sv
// skl_heap_eng: ram-held binary max-heap with sequenced push and pop
// depends on skl_pkg and skl_ram
module skl_heap_eng (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  skl_pkg::heap_cmd_t cmd_i,
  output skl_pkg::heap_sts_t sts_o
);

  localparam logic [2:0] E_IDLE      = 3'd0;
  localparam logic [2:0] E_PUSH_TEST = 3'd1;
  localparam logic [2:0] E_PUSH_CMP  = 3'd2;
  localparam logic [2:0] E_POP_LAST  = 3'd3;
  localparam logic [2:0] E_POP_TEST  = 3'd4;
  localparam logic [2:0] E_POP_L     = 3'd5;
  localparam logic [2:0] E_POP_R     = 3'd6;

  logic [2:0]                   st_q, st_d;
  logic [skl_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [skl_pkg::HADDR_W-1:0]  idx_q, idx_d;
  skl_pkg::ent_t                ent_q, ent_d;
  skl_pkg::ent_t                cl_q, cl_d;
  skl_pkg::ent_t                top_q;

  logic                         we;
  logic [skl_pkg::HADDR_W-1:0]  wa, ra, par;
  skl_pkg::ent_t                wd, rd, pk;
  logic [skl_pkg::CHILD_W-1:0]  c_w, cr_w, n_w, pi;
  logic                         dec;

  skl_ram #(
    .WIDTH(skl_pkg::ENT_W),
    .AW   (skl_pkg::HADDR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wa),
    .wdata_i(wd),
    .raddr_i(ra),
    .rdata_o(rd)
  );

  assign c_w  = {idx_q, 1'b1};
  assign cr_w = c_w + skl_pkg::CHILD_W'(1);
  assign n_w  = skl_pkg::CHILD_W'(cnt_q);
  assign par  = (idx_q - skl_pkg::HADDR_W'(1)) >> 1;

  // larger child select
  always_comb begin
    dec = 1'b0;
    pk  = rd;
    pi  = c_w;
    if (st_q == E_POP_L && !(cr_w < n_w)) begin
      dec = 1'b1;
    end else if (st_q == E_POP_R) begin
      dec = 1'b1;
      if (rd > cl_q) begin
        pi = cr_w;
      end else begin
        pk = cl_q;
      end
    end
  end

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    ent_d = ent_q;
    cl_d  = cl_q;
    we    = 1'b0;
    wa    = idx_q;
    wd    = ent_q;
    ra    = '0;
    case (st_q)
      E_IDLE: begin
        if (cmd_i.push) begin
          ent_d = cmd_i.ent;
          idx_d = cnt_q[skl_pkg::HADDR_W-1:0];
          cnt_d = cnt_q + skl_pkg::CNT_W'(1);
          st_d  = E_PUSH_TEST;
        end else if (cmd_i.pop) begin
          cnt_d = cnt_q - skl_pkg::CNT_W'(1);
          ra    = cnt_d[skl_pkg::HADDR_W-1:0];
          st_d  = E_POP_LAST;
        end
      end
      E_PUSH_TEST: begin
        if (idx_q == '0) begin
          we   = 1'b1;
          st_d = E_IDLE;
        end else begin
          ra   = par;
          st_d = E_PUSH_CMP;
        end
      end
      E_PUSH_CMP: begin
        we = 1'b1;
        if (rd >= ent_q) begin
          st_d = E_IDLE;
        end else begin
          wd    = rd;
          idx_d = par;
          st_d  = E_PUSH_TEST;
        end
      end
      E_POP_LAST: begin
        if (cnt_q == '0) begin
          st_d = E_IDLE;
        end else begin
          ent_d = rd;
          idx_d = '0;
          st_d  = E_POP_TEST;
        end
      end
      E_POP_TEST: begin
        if (c_w >= n_w) begin
          we   = 1'b1;
          st_d = E_IDLE;
        end else begin
          ra   = c_w[skl_pkg::HADDR_W-1:0];
          st_d = E_POP_L;
        end
      end
      E_POP_L: begin
        if (cr_w < n_w) begin
          cl_d = rd;
          ra   = cr_w[skl_pkg::HADDR_W-1:0];
          st_d = E_POP_R;
        end
      end
      E_POP_R: begin
        st_d = st_q;
      end
      default: begin
        st_d = E_IDLE;
      end
    endcase
    // sift-down step shared by both child reads
    if (dec) begin
      we = 1'b1;
      if (pk <= ent_q) begin
        st_d = E_IDLE;
      end else begin
        wd    = pk;
        idx_d = pi[skl_pkg::HADDR_W-1:0];
        st_d  = E_POP_TEST;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= E_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    ent_q <= ent_d;
    cl_q  <= cl_d;
    if (we && wa == '0) begin
      top_q <= wd;
    end
  end

  assign sts_o.busy  = (st_q != E_IDLE);
  assign sts_o.count = cnt_q;
  assign sts_o.top   = top_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= skl_pkg::CNT_W'(skl_pkg::HEAP_DEPTH))
    else $error("heap count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == E_IDLE && cmd_i.pop && !cmd_i.push) |-> cnt_q != '0)
    else $error("pop on empty heap");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == E_IDLE && cmd_i.push) |-> cnt_q != skl_pkg::CNT_W'(skl_pkg::HEAP_DEPTH))
    else $error("push on full heap");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == E_POP_TEST) |-> skl_pkg::CNT_W'(idx_q) < cnt_q)
    else $error("sift index outside heap");

endmodule

### rtl/skyline_sweep_max_heap.sv
// skyline_sweep_max_heap: skyline key points from buildings sorted by left edge
// depends on skl_pkg, skl_heap_eng and skl_ram
//
// One building is a transaction on start/busy; all key points that it causes
// are first collected in a result ram and then shown one per cycle on
// point_valid_o, back to back, with run_last_o on the last one of the
// transaction and skyline_done_o on the last point of a skyline. The receiver
// cannot stall, so every strobed point must be taken at once. The time an item
// takes grows with each heap pop and its sift-down, with the push and its
// sift-up, with the drain pass and flush on a final building and with each
// emitted point; the heap ram walk (one read per cycle, registered read)
// sets it. busy stays high until the last point has been read from the
// result ram; the final strobe lands in the first cycle busy is low.
module skyline_sweep_max_heap (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [skl_pkg::FIELD_W-1:0] left_edge_i,
  input  logic [skl_pkg::FIELD_W-1:0] right_edge_i,
  input  logic [skl_pkg::FIELD_W-1:0] bldg_height_i,
  input  logic                        final_building_i,
  output logic                        point_valid_o,
  output logic [skl_pkg::FIELD_W-1:0] point_x_o,
  output logic [skl_pkg::FIELD_W-1:0] point_height_o,
  output logic                        run_last_o,
  output logic                        skyline_done_o,
  output logic                        heap_overflow_o
);

  localparam int unsigned CB = skl_pkg::COORD_BITS;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RUN_INIT = 4'd1;
  localparam logic [3:0] S_RUN_CHK  = 4'd2;
  localparam logic [3:0] S_RUN_WAIT = 4'd3;
  localparam logic [3:0] S_BLD      = 4'd4;
  localparam logic [3:0] S_PUSH     = 4'd5;
  localparam logic [3:0] S_PUSH_W   = 4'd6;
  localparam logic [3:0] S_FLUSH    = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  logic [3:0]                st_q, st_d;
  logic                      drain_q, drain_d;
  logic                      flushed_q, flushed_d;
  logic                      sticky_q, sticky_d;
  logic                      pend_v_q, pend_v_d;
  logic [CB-1:0]             pend_x_q, pend_x_d, pend_h_q, pend_h_d;
  logic [CB-1:0]             left_q, right_q, hgt_q;
  logic                      final_q;
  skl_pkg::ent_t             cur_q, cur_d;
  logic [skl_pkg::BCNT_W-1:0] bn_q, bn_d, nout_q, nout_d, ridx_q, ridx_d;
  logic                      pv_q, pv_d, rl_q, rl_d, sd_q, sd_d;

  skl_pkg::heap_cmd_t        hcmd;
  skl_pkg::heap_sts_t        hsts;
  logic [CB-1:0]             top_h, top_r, cur_r;

  // point handoff to the pending slot
  logic                      pp_en, pp_bld;
  logic [CB-1:0]             pp_x, pp_h;
  logic                      ap_en;
  logic [CB-1:0]             ap_x, ap_h;
  logic [skl_pkg::BUF_AW-1:0] bwa, bra;
  skl_pkg::ent_t             brd;

  skl_heap_eng u_heap (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (hcmd),
    .sts_o (hsts)
  );

  skl_ram #(
    .WIDTH(skl_pkg::ENT_W),
    .AW   (skl_pkg::BUF_AW)
  ) u_res (
    .clk_i  (clk_i),
    .we_i   (ap_en),
    .waddr_i(bwa),
    .wdata_i({ap_h, ap_x}),
    .raddr_i(bra),
    .rdata_o(brd)
  );

  assign top_h = hsts.top[skl_pkg::ENT_W-1:CB];
  assign top_r = hsts.top[CB-1:0];
  assign cur_r = cur_q[CB-1:0];

  // past the result limit the newest point overwrites the last slot
  assign bwa = (bn_q < skl_pkg::BCNT_W'(skl_pkg::MAX_RESULTS)) ?
               bn_q[skl_pkg::BUF_AW-1:0] :
               skl_pkg::BUF_AW'(skl_pkg::MAX_RESULTS - 1);
  assign bra = ridx_q[skl_pkg::BUF_AW-1:0];

  always_comb begin
    st_d      = st_q;
    drain_d   = drain_q;
    flushed_d = flushed_q;
    sticky_d  = sticky_q;
    cur_d     = cur_q;
    nout_d    = nout_q;
    ridx_d    = ridx_q;
    pv_d      = 1'b0;
    rl_d      = 1'b0;
    sd_d      = 1'b0;
    hcmd.push = 1'b0;
    hcmd.pop  = 1'b0;
    hcmd.ent  = {hgt_q, right_q};
    pp_en     = 1'b0;
    pp_bld    = 1'b0;
    pp_x      = cur_r;
    pp_h      = '0;
    ap_en     = 1'b0;
    ap_x      = pend_x_q;
    ap_h      = pend_h_q;
    pend_v_d  = pend_v_q;
    pend_x_d  = pend_x_q;
    pend_h_d  = pend_h_q;
    case (st_q)
      S_IDLE: begin
        if (start) begin
          drain_d   = 1'b0;
          flushed_d = 1'b0;
          st_d      = S_RUN_INIT;
        end
      end
      S_RUN_INIT: begin
        cur_d = hsts.top;
        st_d  = S_RUN_CHK;
      end
      S_RUN_CHK: begin
        if (hsts.count != '0 && (drain_q || top_r < left_q)) begin
          hcmd.pop = 1'b1;
          st_d     = S_RUN_WAIT;
        end else begin
          st_d = drain_q ? S_FLUSH : S_BLD;
        end
      end
      S_RUN_WAIT: begin
        if (!hsts.busy) begin
          if (hsts.count == '0) begin
            pp_en = 1'b1;
            st_d  = drain_q ? S_FLUSH : S_BLD;
          end else begin
            if (top_r > cur_r) begin
              pp_en = 1'b1;
              pp_h  = top_h;
              cur_d = hsts.top;
            end
            st_d = S_RUN_CHK;
          end
        end
      end
      S_BLD: begin
        if (hsts.count == '0 || top_h < hgt_q) begin
          pp_en  = 1'b1;
          pp_bld = 1'b1;
          pp_x   = left_q;
          pp_h   = hgt_q;
        end
        st_d = S_PUSH;
      end
      S_PUSH: begin
        if (hsts.count < skl_pkg::CNT_W'(skl_pkg::HEAP_DEPTH)) begin
          hcmd.push = 1'b1;
          st_d      = S_PUSH_W;
        end else begin
          sticky_d = 1'b1;
          drain_d  = final_q;
          st_d     = final_q ? S_RUN_INIT : S_FIN;
        end
      end
      S_PUSH_W: begin
        if (!hsts.busy) begin
          drain_d = final_q;
          st_d    = final_q ? S_RUN_INIT : S_FIN;
        end
      end
      S_FLUSH: begin
        if (pend_v_q) begin
          ap_en     = 1'b1;
          pend_v_d  = 1'b0;
          pend_x_d  = '0;
          pend_h_d  = '0;
          flushed_d = 1'b1;
        end
        st_d = S_FIN;
      end
      S_FIN: begin
        ridx_d = '0;
        if (bn_q > skl_pkg::BCNT_W'(skl_pkg::MAX_RESULTS)) begin
          sticky_d = 1'b1;
          nout_d   = skl_pkg::BCNT_W'(skl_pkg::MAX_RESULTS);
        end else begin
          nout_d = bn_q;
        end
        st_d = (bn_q == '0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        pv_d   = 1'b1;
        ridx_d = ridx_q + skl_pkg::BCNT_W'(1);
        if (ridx_d == nout_q) begin
          rl_d = 1'b1;
          sd_d = flushed_q;
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
    // a new point releases the held one unless it retracts it
    if (pp_en) begin
      ap_en    = pend_v_q &&
                 !(pp_bld && pend_x_q == pp_x && pend_h_q < pp_h);
      pend_v_d = 1'b1;
      pend_x_d = pp_x;
      pend_h_d = pp_h;
    end
  end

  always_comb begin
    bn_d = bn_q;
    if (st_q == S_IDLE) begin
      bn_d = '0;
    end else if (ap_en) begin
      bn_d = bn_q + skl_pkg::BCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      drain_q   <= 1'b0;
      flushed_q <= 1'b0;
      sticky_q  <= 1'b0;
      pend_v_q  <= 1'b0;
      pend_x_q  <= '0;
      pend_h_q  <= '0;
      bn_q      <= '0;
      nout_q    <= '0;
      ridx_q    <= '0;
      pv_q      <= 1'b0;
      rl_q      <= 1'b0;
      sd_q      <= 1'b0;
    end else begin
      st_q      <= st_d;
      drain_q   <= drain_d;
      flushed_q <= flushed_d;
      sticky_q  <= sticky_d;
      pend_v_q  <= pend_v_d;
      pend_x_q  <= pend_x_d;
      pend_h_q  <= pend_h_d;
      bn_q      <= bn_d;
      nout_q    <= nout_d;
      ridx_q    <= ridx_d;
      pv_q      <= pv_d;
      rl_q      <= rl_d;
      sd_q      <= sd_d;
    end
  end

  // transaction payload capture
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (st_q == S_IDLE && start) begin
      left_q  <= left_edge_i[CB-1:0];
      right_q <= right_edge_i[CB-1:0];
      hgt_q   <= bldg_height_i[CB-1:0];
      final_q <= final_building_i;
    end
  end

  assign busy            = (st_q != S_IDLE);
  assign point_valid_o   = pv_q;
  assign point_x_o       = skl_pkg::FIELD_W'(brd[CB-1:0]);
  assign point_height_o  = skl_pkg::FIELD_W'(brd[skl_pkg::ENT_W-1:CB]);
  assign run_last_o      = pv_q & rl_q;
  assign skyline_done_o  = pv_q & sd_q;
  assign heap_overflow_o = sticky_q;

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skyline_done_o |-> run_last_o)
    else $error("skyline done without run last");
  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bn_q <= skl_pkg::BCNT_W'(skl_pkg::HEAP_DEPTH + 3))
    else $error("result count beyond bound");
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o |-> $past(st_q) == S_EMIT)
    else $error("point strobe outside emit");
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skyline_done_o |-> (hsts.count == '0 && !pend_v_q))
    else $error("skyline done with state left");

endmodule

### tb/skyline_sweep_max_heap_chk.sv
// skyline_sweep_max_heap_chk: watches the building and key point channels,
// keeps its own max-heap sweep and compares every strobed point
// depends on skl_pkg for the heap depth, the widths and the result limit
module skyline_sweep_max_heap_chk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic [skl_pkg::FIELD_W-1:0] left_edge_i,
  input  logic [skl_pkg::FIELD_W-1:0] right_edge_i,
  input  logic [skl_pkg::FIELD_W-1:0] bldg_height_i,
  input  logic                        final_building_i,
  input  logic                        point_valid_i,
  input  logic [skl_pkg::FIELD_W-1:0] point_x_i,
  input  logic [skl_pkg::FIELD_W-1:0] point_height_i,
  input  logic                        run_last_i,
  input  logic                        skyline_done_i,
  input  logic                        heap_overflow_i,
  output int                          err_cnt_o,
  output int                          points_owed_o
);

  localparam int unsigned HEAP_DEPTH  = skl_pkg::HEAP_DEPTH;
  localparam int unsigned COORD_BITS  = skl_pkg::COORD_BITS;
  localparam int unsigned FIELD_W     = skl_pkg::FIELD_W;
  localparam int unsigned ENT_W       = skl_pkg::ENT_W;
  localparam int unsigned MAX_RESULTS = skl_pkg::MAX_RESULTS;
  localparam int unsigned PT_CAP      = HEAP_DEPTH + 4;

  typedef struct packed {
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] h;
    logic               run_last;
    logic               done;
    logic               ovf;
  } key_point_t;

  logic [ENT_W-1:0]   sky_heap [HEAP_DEPTH];
  int unsigned        sky_cnt;
  logic               hold_vld;
  logic [FIELD_W-1:0] hold_x;
  logic [FIELD_W-1:0] hold_h;
  logic               ovf_sticky;
  logic [FIELD_W-1:0] new_x [$];
  logic [FIELD_W-1:0] new_h [$];
  key_point_t         owed_points [$];
  int                 err_cnt;

  assign err_cnt_o = err_cnt;

  function automatic logic [FIELD_W-1:0] ent_right(logic [ENT_W-1:0] e);
    return e[COORD_BITS-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] ent_height(logic [ENT_W-1:0] e);
    return e[ENT_W-1:COORD_BITS];
  endfunction

  task automatic heap_insert(input logic [ENT_W-1:0] e);
    int unsigned i;
    int unsigned p;
    i = sky_cnt;
    sky_cnt++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (sky_heap[p] >= e) break;
      sky_heap[i] = sky_heap[p];
      i = p;
    end
    sky_heap[i] = e;
  endtask

  task automatic heap_remove_top();
    int unsigned i;
    int unsigned c;
    logic [ENT_W-1:0] tail;
    i = 0;
    if (sky_cnt == 0) return;
    sky_cnt--;
    if (sky_cnt == 0) return;
    tail = sky_heap[sky_cnt];
    forever begin
      c = 2 * i + 1;
      if (c >= sky_cnt) break;
      if (c + 1 < sky_cnt && sky_heap[c+1] > sky_heap[c]) c++;
      if (sky_heap[c] <= tail) break;
      sky_heap[i] = sky_heap[c];
      i = c;
    end
    sky_heap[i] = tail;
  endtask

  task automatic add_point(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] h);
    if (new_x.size() < PT_CAP) begin
      new_x = {new_x, x};
      new_h = {new_h, h};
    end
  endtask

  // the held point is dropped when a building at the same x rises above it
  task automatic offer_point(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] h,
                             input logic from_bldg);
    if (hold_vld && !(from_bldg && hold_x == x && hold_h < h)) add_point(hold_x, hold_h);
    hold_vld = 1'b1;
    hold_x   = x;
    hold_h   = h;
  endtask

  // lazy expiry; with drain set the whole heap goes
  task automatic expire_runs(input logic drain, input logic [FIELD_W-1:0] left);
    logic [ENT_W-1:0] cur;
    if (sky_cnt == 0) return;
    cur = sky_heap[0];
    while (sky_cnt > 0 && (drain || ent_right(sky_heap[0]) < left)) begin
      heap_remove_top();
      if (sky_cnt == 0) begin
        offer_point(ent_right(cur), '0, 1'b0);
        break;
      end
      if (ent_right(sky_heap[0]) > ent_right(cur)) begin
        offer_point(ent_right(cur), ent_height(sky_heap[0]), 1'b0);
        cur = sky_heap[0];
      end
    end
  endtask

  task automatic predict_building(input logic [FIELD_W-1:0] l, input logic [FIELD_W-1:0] r,
                                  input logic [FIELD_W-1:0] h, input logic fin);
    logic       flushed;
    key_point_t kp;
    int         n;
    flushed = 1'b0;
    new_x.delete();
    new_h.delete();
    expire_runs(1'b0, l);
    if (sky_cnt == 0 || ent_height(sky_heap[0]) < h) offer_point(l, h, 1'b1);
    if (sky_cnt < HEAP_DEPTH) heap_insert({h, r});
    else ovf_sticky = 1'b1;
    if (fin) begin
      expire_runs(1'b1, '0);
      if (hold_vld) begin
        add_point(hold_x, hold_h);
        hold_vld = 1'b0;
        hold_x   = '0;
        hold_h   = '0;
        flushed  = 1'b1;
      end
    end
    // one point too many: the second-to-last goes, the last stays
    n = new_x.size();
    if (n > MAX_RESULTS) begin
      new_x[MAX_RESULTS-1] = new_x[n-1];
      new_h[MAX_RESULTS-1] = new_h[n-1];
      n = MAX_RESULTS;
      ovf_sticky = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      kp.x        = new_x[k];
      kp.h        = new_h[k];
      kp.run_last = (k == n - 1);
      kp.done     = (k == n - 1) && flushed;
      kp.ovf      = ovf_sticky;
      owed_points = {owed_points, kp};
    end
  endtask

  task automatic report(input string what, input logic [FIELD_W-1:0] got,
                        input logic [FIELD_W-1:0] want);
    $display("MISMATCH %0t: %s got %0h expected %0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  initial begin
    err_cnt       = 0;
    points_owed_o = 0;
    sky_cnt       = 0;
    hold_vld      = 1'b0;
    hold_x        = '0;
    hold_h        = '0;
    ovf_sticky    = 1'b0;
  end

  always @(posedge clk_i) begin
    key_point_t want;
    if (rst_ni) begin
      if (point_valid_i) begin
        if (owed_points.size() == 0) begin
          report("unexpected point x", point_x_i, '0);
        end else begin
          want = owed_points.pop_front();
          if (point_x_i !== want.x) report("point_x", point_x_i, want.x);
          if (point_height_i !== want.h) report("point_height", point_height_i, want.h);
          if (run_last_i !== want.run_last)
            report("run_last", FIELD_W'(run_last_i), FIELD_W'(want.run_last));
          if (skyline_done_i !== want.done)
            report("skyline_done", FIELD_W'(skyline_done_i), FIELD_W'(want.done));
          if (heap_overflow_i !== want.ovf)
            report("heap_overflow", FIELD_W'(heap_overflow_i), FIELD_W'(want.ovf));
        end
      end
      if (start && !busy)
        predict_building(left_edge_i, right_edge_i, bldg_height_i, final_building_i);
      points_owed_o = owed_points.size();
    end
  end

endmodule

### tb/skyline_sweep_max_heap_tb.sv
// skyline_sweep_max_heap_tb: drives buildings into the skyline block and
// gives the verdict; checking lives in skyline_sweep_max_heap_chk
// depends on skl_pkg, the block and the checker
module skyline_sweep_max_heap_tb;

  localparam int unsigned HEAP_DEPTH = skl_pkg::HEAP_DEPTH;
  localparam int unsigned FIELD_W    = skl_pkg::FIELD_W;

  // cycles with no transaction on either side before the run is declared hung
  localparam int WATCHDOG_LIMIT = 6000;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [FIELD_W-1:0] left_edge_i;
  logic [FIELD_W-1:0] right_edge_i;
  logic [FIELD_W-1:0] bldg_height_i;
  logic               final_building_i;
  logic               point_valid_o;
  logic [FIELD_W-1:0] point_x_o;
  logic [FIELD_W-1:0] point_height_o;
  logic               run_last_o;
  logic               skyline_done_o;
  logic               heap_overflow_o;
  int                 err_cnt;
  int                 points_owed;
  int                 quiet_cycles;
  logic               zero_gaps;      // a stretch of back-to-back buildings
  logic [FIELD_W-1:0] sweep_x;        // running left edge of the skyline under way

  skyline_sweep_max_heap DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .left_edge_i      (left_edge_i),
    .right_edge_i     (right_edge_i),
    .bldg_height_i    (bldg_height_i),
    .final_building_i (final_building_i),
    .point_valid_o    (point_valid_o),
    .point_x_o        (point_x_o),
    .point_height_o   (point_height_o),
    .run_last_o       (run_last_o),
    .skyline_done_o   (skyline_done_o),
    .heap_overflow_o  (heap_overflow_o)
  );

  skyline_sweep_max_heap_chk u_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .left_edge_i      (left_edge_i),
    .right_edge_i     (right_edge_i),
    .bldg_height_i    (bldg_height_i),
    .final_building_i (final_building_i),
    .point_valid_i    (point_valid_o),
    .point_x_i        (point_x_o),
    .point_height_i   (point_height_o),
    .run_last_i       (run_last_o),
    .skyline_done_i   (skyline_done_o),
    .heap_overflow_i  (heap_overflow_o),
    .err_cnt_o        (err_cnt),
    .points_owed_o    (points_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog: counts cycles in which no transaction happens on either side
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((start && !busy) || point_valid_o || !rst_ni) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // one building transaction: random gap, then hold start until busy is low;
  // busy only moves after a rising edge, so reading it at the falling edge
  // tells whether the coming rising edge accepts
  task automatic send_building(input logic [FIELD_W-1:0] l, input logic [FIELD_W-1:0] r,
                               input logic [FIELD_W-1:0] h, input logic fin);
    int  gap;
    logic took;
    gap = zero_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start            = 1'b1;
    left_edge_i      = l;
    right_edge_i     = r;
    bldg_height_i    = h;
    final_building_i = fin;
    do begin
      took = !busy;
      @(negedge clk_i);
    end while (!took);
    start = 1'b0;
    if ($urandom_range(0, 19) == 0) zero_gaps = ~zero_gaps;
  endtask

  // one sorted skyline with random content; widths and heights kept small so
  // that runs overlap, expire, tie and retract often
  task automatic send_skyline(input int n_bldg);
    logic [FIELD_W-1:0] r;
    logic [FIELD_W-1:0] h;
    for (int i = 0; i < n_bldg; i++) begin
      // same left edge now and then, to hit the retraction
      if ($urandom_range(0, 3) != 0) sweep_x = sweep_x + $urandom_range(0, 12);
      r = sweep_x + $urandom_range(0, 20);
      h = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 15);
      send_building(sweep_x, r, h, i == n_bldg - 1);
    end
  endtask

  initial begin
    int sent;
    rst_ni           = 1'b0;
    start            = 1'b0;
    left_edge_i      = '0;
    right_edge_i     = '0;
    bldg_height_i    = '0;
    final_building_i = 1'b0;
    zero_gaps        = 1'b0;
    sweep_x          = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: lone building, then extremes of every field
    send_building(32'd10, 32'd20, 32'd5, 1'b1);
    send_building('0, '0, '0, 1'b1);
    send_building(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_building('0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_building(32'h8000_0000, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 1'b1);
    // same left edge, taller second: the first point is retracted
    send_building(32'd5, 32'd9, 32'd3, 1'b0);
    send_building(32'd5, 32'd8, 32'd7, 1'b1);
    // same left edge, lower second: no retraction
    send_building(32'd5, 32'd9, 32'd7, 1'b0);
    send_building(32'd5, 32'd12, 32'd3, 1'b1);
    // right edge equal to next left: strict test keeps it alive
    send_building(32'd0, 32'd4, 32'd6, 1'b0);
    send_building(32'd4, 32'd8, 32'd2, 1'b0);
    // gap with ground, then nested and equal-height runs
    send_building(32'd20, 32'd30, 32'd2, 1'b0);
    send_building(32'd22, 32'd26, 32'd9, 1'b0);
    send_building(32'd23, 32'd26, 32'd9, 1'b0);
    send_building(32'd24, 32'd40, 32'd9, 1'b1);
    // unsorted pair
    send_building(32'd50, 32'd60, 32'd4, 1'b0);
    send_building(32'd10, 32'd12, 32'd8, 1'b1);

    // pause until every point is out
    start = 1'b0;
    while (points_owed != 0) @(negedge clk_i);

    // deep heap: staircase of falling heights and growing right edges that
    // overflows the heap; a far final building then expires the whole heap,
    // which yields one point too many
    for (int i = 0; i < HEAP_DEPTH + 2; i++)
      send_building(FIELD_W'(i), FIELD_W'(1000 + i), FIELD_W'(200 - i), 1'b0);
    send_building(32'd5000, 32'd5010, 32'd5, 1'b1);

    sent = 17 + HEAP_DEPTH + 3;
    while (sent < 350) begin
      case ($urandom_range(0, 9))
        0: begin
          // noise across the full range of every field
          send_building($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
          sent++;
        end
        1: begin
          // near the top of the coordinate range
          sweep_x = 32'hFFFF_FF00 + $urandom_range(0, 200);
          send_skyline(3);
          sent += 3;
        end
        default: begin
          int n;
          n = $urandom_range(1, 14);
          sweep_x = $urandom_range(0, 1000);
          send_skyline(n);
          sent += n;
        end
      endcase
    end
    // close any skyline left open by noise
    send_building(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd1, 1'b1);

    while (points_owed != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
